[sv/smpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpc_pkg
// Widths, calibration constants and shared types of the soil moisture
// percent calculator.
// ----------------------------------------------------------------------------
package smpc_pkg;

  // field widths
  localparam int SAMPLE_W = 13;
  localparam int TEMP_W   = 12;
  localparam int MOIST_W  = 14;
  localparam int DRY_W    = 13;
  localparam int WET_W    = 12;

  // internal widths
  localparam int SUM_W    = SAMPLE_W + 2;     // three samples
  localparam int CALNUM_W = 23;               // supply*198 + 3597759 < 2^23
  localparam int DIFF_W   = TEMP_W + 1;       // temperature minus reference
  localparam int MAG_W    = 12;               // |diff| <= 2298
  localparam int MAG21_W  = 16;               // |diff| * 21
  localparam int COMP_W   = 14;               // |diff| * 21 / 5 <= 9651
  localparam int LEVEL_W  = 15;               // average plus compensation

  // calibration lines
  localparam int DRY_SLOPE  = 198;
  localparam int DRY_OFFSET = 3597759;
  localparam int WET_SLOPE  = 171;
  localparam int WET_OFFSET = 2060895;

  // compensation: 420/100 reduced to 21/5, reference 25.0 C
  localparam int TEMP_REF   = 250;
  localparam int COMP_RATIO = 21;

  // reciprocal constants: floor(x / d) == (x * RECIP) >> SHIFT over the range
  localparam int RECIP_3       = 21846;
  localparam int RECIP_3_SH    = 16;
  localparam int RECIP_1000    = 8589935;
  localparam int RECIP_1000_W  = 24;
  localparam int RECIP_1000_SH = 33;
  localparam int RECIP_5       = 52429;
  localparam int RECIP_5_SH    = 18;

  localparam int AVGPROD_W  = SUM_W + 16;
  localparam int CALPROD_W  = CALNUM_W + RECIP_1000_W;
  localparam int COMPPROD_W = MAG21_W + 16;

  // moisture scale
  localparam int FULL_WET = 10000;
  localparam int MID_WET  = 5000;

  // divider: quotient below 2^MOIST_W, two quotient bits per stage
  localparam int DEN_W       = DRY_W;
  localparam int NUM_W       = DEN_W + MOIST_W;
  localparam int DIV_STEP    = 2;
  localparam int DIV_STAGES  = MOIST_W / DIV_STEP;

  typedef struct packed {
    logic [SAMPLE_W-1:0] soil_average;
    logic [DRY_W-1:0]    dry_point;
    logic [WET_W-1:0]    wet_point;
    logic [LEVEL_W-1:0]  level;
  } front_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] soil_average;
    logic [DRY_W-1:0]    dry_point;
    logic [WET_W-1:0]    wet_point;
    logic [MOIST_W-1:0]  moist_fixed;
    logic                use_div;
  } side_t;

endpackage

[sv/smpc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpc_in_if
// Reading channel: supply reading, three soil samples and temperature.
// ----------------------------------------------------------------------------
interface smpc_in_if import smpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_W-1:0]      supply_raw;
  logic [SAMPLE_W-1:0]      soil_sample_first;
  logic [SAMPLE_W-1:0]      soil_sample_second;
  logic [SAMPLE_W-1:0]      soil_sample_third;
  logic signed [TEMP_W-1:0] temp_tenths;

  modport source (
    output valid, supply_raw, soil_sample_first, soil_sample_second,
           soil_sample_third, temp_tenths,
    input  ready
  );

  modport sink (
    input  valid, supply_raw, soil_sample_first, soil_sample_second,
           soil_sample_third, temp_tenths,
    output ready
  );
endinterface

[sv/smpc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpc_out_if
// Result channel: moisture, soil average and the two calibration points.
// ----------------------------------------------------------------------------
interface smpc_out_if import smpc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MOIST_W-1:0]  moisture_hundredths;
  logic [SAMPLE_W-1:0] soil_average;
  logic [DRY_W-1:0]    dry_point;
  logic [WET_W-1:0]    wet_point;

  modport source (
    output valid, moisture_hundredths, soil_average, dry_point, wet_point,
    input  ready
  );

  modport sink (
    input  valid, moisture_hundredths, soil_average, dry_point, wet_point,
    output ready
  );
endinterface

[sv/smpc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpc_front
// Three-stage front end: sums and calibration numerators, reciprocal
// multiplies, then average, calibration points and compensated level.
// ----------------------------------------------------------------------------
module smpc_front import smpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  smpc_in_if.sink      reading,
  input  logic         comp_enable,
  output logic         out_valid,
  input  logic         out_ready,
  output front_t       out_data
);

  // stage A
  logic                a_valid;
  logic                a_ready;
  logic [SUM_W-1:0]    a_sum;
  logic [CALNUM_W-1:0] a_dry_num;
  logic [CALNUM_W-1:0] a_wet_num;
  logic [MAG21_W-1:0]  a_mag21;
  logic                a_neg;
  logic                a_comp_en;

  // stage B
  logic                  b_valid;
  logic                  b_ready;
  logic [AVGPROD_W-1:0]  b_avg_prod;
  logic [CALPROD_W-1:0]  b_dry_prod;
  logic [CALPROD_W-1:0]  b_wet_prod;
  logic [COMPPROD_W-1:0] b_comp_prod;
  logic                  b_neg;
  logic                  b_comp_en;

  // stage C
  logic   c_valid;
  logic   c_ready;
  front_t c_data;

  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]         mag;
  logic [SAMPLE_W-1:0]      avg;
  logic [COMP_W-1:0]        comp;
  logic [LEVEL_W-1:0]       level_next;

  assign a_ready = !a_valid || b_ready;
  assign b_ready = !b_valid || c_ready;
  assign c_ready = !c_valid || out_ready;
  assign reading.ready = a_ready;

  always_comb begin
    diff = DIFF_W'(reading.temp_tenths) - DIFF_W'(TEMP_REF);
    if (diff < 0) begin
      mag = MAG_W'(-diff);
    end else begin
      mag = MAG_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= reading.valid;
    end
    if (a_ready && reading.valid) begin
      a_sum     <= SUM_W'(reading.soil_sample_first) + SUM_W'(reading.soil_sample_second)
                 + SUM_W'(reading.soil_sample_third);
      a_dry_num <= CALNUM_W'(32'(reading.supply_raw) * 32'(DRY_SLOPE) + 32'(DRY_OFFSET));
      a_wet_num <= CALNUM_W'(32'(reading.supply_raw) * 32'(WET_SLOPE) + 32'(WET_OFFSET));
      a_mag21   <= MAG21_W'(mag) * MAG21_W'(COMP_RATIO);
      a_neg     <= diff < 0;
      a_comp_en <= comp_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_avg_prod  <= AVGPROD_W'(a_sum) * AVGPROD_W'(RECIP_3);
      b_dry_prod  <= CALPROD_W'(a_dry_num) * CALPROD_W'(RECIP_1000);
      b_wet_prod  <= CALPROD_W'(a_wet_num) * CALPROD_W'(RECIP_1000);
      b_comp_prod <= COMPPROD_W'(a_mag21) * COMPPROD_W'(RECIP_5);
      b_neg       <= a_neg;
      b_comp_en   <= a_comp_en;
    end
  end

  // compensated level, clamped at zero when the term is positive
  always_comb begin
    avg  = b_avg_prod[RECIP_3_SH +: SAMPLE_W];
    comp = b_comp_prod[RECIP_5_SH +: COMP_W];
    if (!b_comp_en) begin
      level_next = LEVEL_W'(avg);
    end else if (b_neg) begin
      level_next = LEVEL_W'(avg) + LEVEL_W'(comp);
    end else if (LEVEL_W'(comp) > LEVEL_W'(avg)) begin
      level_next = '0;
    end else begin
      level_next = LEVEL_W'(avg) - LEVEL_W'(comp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
    if (c_ready && b_valid) begin
      c_data.soil_average <= avg;
      c_data.dry_point    <= b_dry_prod[RECIP_1000_SH +: DRY_W];
      c_data.wet_point    <= b_wet_prod[RECIP_1000_SH +: WET_W];
      c_data.level        <= level_next;
    end
  end

  assign out_valid = c_valid;
  assign out_data  = c_data;

endmodule

[sv/smpc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpc_div
// Pipelined restoring divider, two quotient bits per stage. The numerator
// must stay below den * 2^MOIST_W; side data travels alongside.
// ----------------------------------------------------------------------------
module smpc_div import smpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  input  side_t              in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MOIST_W-1:0] quotient,
  output side_t              out_side
);

  logic [DIV_STAGES-1:0] st_valid;
  logic [DIV_STAGES-1:0] st_ready;
  logic [DEN_W-1:0]      st_rem  [DIV_STAGES];
  logic [MOIST_W-1:0]    st_sh   [DIV_STAGES];
  logic [DEN_W-1:0]      st_den  [DIV_STAGES];
  side_t                 st_side [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic               up_valid;
    logic [DEN_W-1:0]   up_rem;
    logic [MOIST_W-1:0] up_sh;
    logic [DEN_W-1:0]   up_den;
    side_t              up_side;
    logic               dn_ready;
    logic [DEN_W-1:0]   rem_next;
    logic [MOIST_W-1:0] sh_next;
    logic [DEN_W:0]     trial;

    if (k == 0) begin : g_first
      // upper numerator bits are already below den
      assign up_valid = in_valid;
      assign up_rem   = num[NUM_W-1 -: DEN_W];
      assign up_sh    = num[MOIST_W-1:0];
      assign up_den   = den;
      assign up_side  = in_side;
    end else begin : g_next
      assign up_valid = st_valid[k-1];
      assign up_rem   = st_rem[k-1];
      assign up_sh    = st_sh[k-1];
      assign up_den   = st_den[k-1];
      assign up_side  = st_side[k-1];
    end

    if (k == DIV_STAGES - 1) begin : g_last
      assign dn_ready = out_ready;
    end else begin : g_mid
      assign dn_ready = st_ready[k+1];
    end

    assign st_ready[k] = !st_valid[k] || dn_ready;

    // for each of the two bits: shift in a numerator bit, subtract when it fits, record quotient bit
    always_comb begin
      rem_next = up_rem;
      sh_next  = up_sh;
      trial    = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
        trial   = {rem_next, sh_next[MOIST_W-1]};
        sh_next = {sh_next[MOIST_W-2:0], 1'b0};
        if (trial >= {1'b0, up_den}) begin
          rem_next   = DEN_W'(trial - {1'b0, up_den});
          sh_next[0] = 1'b1;
        end else begin
          rem_next = trial[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (st_ready[k]) begin
        st_valid[k] <= up_valid;
      end
      if (st_ready[k] && up_valid) begin
        st_rem[k]  <= rem_next;
        st_sh[k]   <= sh_next;
        st_den[k]  <= up_den;
        st_side[k] <= up_side;
      end
    end
  end

  assign in_ready  = st_ready[0];
  assign out_valid = st_valid[DIV_STAGES-1];
  assign quotient  = st_sh[DIV_STAGES-1];
  assign out_side  = st_side[DIV_STAGES-1];

endmodule

[sv/soil_moisture_percent_calc_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soil_moisture_percent_calc_unit
// Soil moisture in hundredths of a percent from supply and probe readings.
// ----------------------------------------------------------------------------
// Usage:
//   reading : valid/ready channel carrying the supply ADC reading, three soil
//             samples and the probe temperature in tenths of a degree.
//   result  : valid/ready channel with moisture (0..10000), the sample
//             average and the dry and wet calibration points.
//   cfg_wr_en / cfg_wr_data : write of the temperature compensation enable;
//             write it only while no transaction is in flight.
// Pipeline: 3 front-end stages, 1 setup stage, 7 divider stages and 1 output
//   register. Throughput: one transaction per cycle until a result stall fills
//   the pipe; every stage is a registered slot with its own valid bit.
// Reset (rst, synchronous): empties every stage and clears the compensation
//   enable. Stall: when result.ready is low the output holds, and the stages
//   behind it keep filling their empty slots until the pipe is full; only
//   then does reading.ready drop.
// ----------------------------------------------------------------------------
module soil_moisture_percent_calc_unit import smpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  smpc_in_if.sink    reading,
  smpc_out_if.source result,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic comp_enable;

  // front end to setup stage
  logic   fr_valid;
  logic   fr_ready;
  front_t fr_data;

  // setup stage: divider operands or a fixed answer
  logic             d_valid;
  logic             d_ready;
  logic [NUM_W-1:0] d_num;
  logic [DEN_W-1:0] d_den;
  side_t            d_side;

  logic             use_div;
  logic [MOIST_W-1:0] fixed_next;
  logic [DEN_W-1:0] span_next;
  logic [DEN_W-1:0] gap_next;

  // divider output
  logic               dv_in_ready;
  logic               dv_valid;
  logic               dv_ready;
  logic [MOIST_W-1:0] dv_quot;
  side_t              dv_side;

  // output register
  logic                o_valid;
  logic [MOIST_W-1:0]  o_moisture;
  logic [SAMPLE_W-1:0] o_average;
  logic [DRY_W-1:0]    o_dry;
  logic [WET_W-1:0]    o_wet;

  // configuration register: keep bit 0 of each write
  always_ff @(posedge clk) begin
    if (rst) begin
      comp_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      comp_enable <= cfg_wr_data;
    end
  end

  smpc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .reading     (reading),
    .comp_enable (comp_enable),
    .out_valid   (fr_valid),
    .out_ready   (fr_ready),
    .out_data    (fr_data)
  );

  // Classify the level against the calibration points. Strictly between
  // them the divider computes (dry - level) * 10000 / (dry - wet); otherwise
  // the answer is fixed and the divider sees 0 / 1.
  always_comb begin
    use_div    = 1'b0;
    fixed_next = '0;
    span_next  = DEN_W'(1);
    gap_next   = '0;
    priority if (fr_data.dry_point > DRY_W'(fr_data.wet_point)
                 && fr_data.level < LEVEL_W'(fr_data.dry_point)
                 && fr_data.level > LEVEL_W'(fr_data.wet_point)) begin
      use_div   = 1'b1;
      span_next = DEN_W'(fr_data.dry_point) - DEN_W'(fr_data.wet_point);
      gap_next  = DEN_W'(fr_data.dry_point) - fr_data.level[DEN_W-1:0];
    end else if (fr_data.level >= LEVEL_W'(fr_data.dry_point)) begin
      fixed_next = '0;
    end else if (fr_data.level <= LEVEL_W'(fr_data.wet_point)) begin
      fixed_next = MOIST_W'(FULL_WET);
    end else begin
      fixed_next = MOIST_W'(MID_WET);
    end
  end

  assign fr_ready = !d_valid || d_ready;
  assign d_ready  = dv_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (fr_ready) begin
      d_valid <= fr_valid;
    end
    if (fr_ready && fr_valid) begin
      d_num               <= NUM_W'(gap_next) * NUM_W'(FULL_WET);
      d_den               <= span_next;
      d_side.soil_average <= fr_data.soil_average;
      d_side.dry_point    <= fr_data.dry_point;
      d_side.wet_point    <= fr_data.wet_point;
      d_side.moist_fixed  <= fixed_next;
      d_side.use_div      <= use_div;
    end
  end

  smpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (dv_in_ready),
    .num       (d_num),
    .den       (d_den),
    .in_side   (d_side),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .quotient  (dv_quot),
    .out_side  (dv_side)
  );

  // output register: parts the divider from the receiver
  assign dv_ready = !o_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (dv_ready) begin
      o_valid <= dv_valid;
    end
    if (dv_ready && dv_valid) begin
      o_moisture <= dv_side.use_div ? dv_quot : dv_side.moist_fixed;
      o_average  <= dv_side.soil_average;
      o_dry      <= dv_side.dry_point;
      o_wet      <= dv_side.wet_point;
    end
  end

  assign result.valid               = o_valid;
  assign result.moisture_hundredths = o_moisture;
  assign result.soil_average        = o_average;
  assign result.dry_point           = o_dry;
  assign result.wet_point           = o_wet;

  // divider operands keep the quotient inside the moisture field
  a_div_range : assert property (@(posedge clk) disable iff (rst)
    d_valid |-> d_num[NUM_W-1 -: DEN_W] < d_den)
    else $error("divider numerator too large for its denominator");

  a_moist_max : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.moisture_hundredths <= MOIST_W'(FULL_WET))
    else $error("moisture above full scale");

  a_points_order : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> DRY_W'(result.wet_point) < result.dry_point)
    else $error("wet point not below dry point");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule

[tb/sv/soil_moisture_percent_calc_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soil_moisture_percent_calc_unit_test
// Self-checking bench for the soil moisture percent calculator. Readings go
// in on the valid/ready channel with random gaps and the result channel
// stalls at random. Each accepted reading is predicted in the bench, and
// each result transaction is compared field by field against the oldest
// prediction. The compensation enable is toggled between drained phases.
// ----------------------------------------------------------------------------
module soil_moisture_percent_calc_unit_test import smpc_pkg::*; ();

  localparam int RESET_CYCLES     = 8;
  localparam int CAL_SCALE        = 1000;
  localparam int COMP_NUM         = 420;
  localparam int COMP_DEN         = 100;
  localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;
  localparam int RANDOM_PHASES    = 6;
  localparam int READINGS_PER_PHASE = 160;
  // settling time after the last predicted readout has come back
  localparam int DRAIN_CYCLES     = 16;
  // worst idle stretch is a long gap plus a long stall plus the pipe
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int MAX_REPORTS      = 200;

  typedef struct {
    logic [SAMPLE_W-1:0]      supply;
    logic [SAMPLE_W-1:0]      first;
    logic [SAMPLE_W-1:0]      second;
    logic [SAMPLE_W-1:0]      third;
    logic signed [TEMP_W-1:0] temp;
  } probe_reading_t;

  typedef struct {
    logic [MOIST_W-1:0]  moisture;
    logic [SAMPLE_W-1:0] average;
    logic [DRY_W-1:0]    dry;
    logic [WET_W-1:0]    wet;
  } moisture_readout_t;

  // Scoreboard: predicts one readout per accepted reading and checks
  // results in order.
  class moisture_scoreboard;
    moisture_readout_t pending_readouts[$];
    bit comp_on;
    int errors;

    // (diff * 420) / 100, truncated toward zero
    static function int comp_counts(int diff);
      int mag;
      mag = (diff < 0) ? -diff : diff;
      mag = mag * COMP_NUM / COMP_DEN;
      return (diff < 0) ? -mag : mag;
    endfunction

    function moisture_readout_t moisture_readout_of(probe_reading_t r);
      moisture_readout_t o;
      int avg, dry, wet, level, moist;
      avg = (int'(r.first) + int'(r.second) + int'(r.third)) / 3;
      dry = (int'(r.supply) * DRY_SLOPE + DRY_OFFSET) / CAL_SCALE;
      wet = (int'(r.supply) * WET_SLOPE + WET_OFFSET) / CAL_SCALE;
      level = avg;
      if (comp_on) begin
        level -= comp_counts(int'(r.temp) - TEMP_REF);
        if (level < 0) level = 0;
      end
      if (dry > wet && level < dry && level > wet)
        moist = (dry - level) * FULL_WET / (dry - wet);
      else if (level >= dry)
        moist = 0;
      else if (level <= wet)
        moist = FULL_WET;
      else
        moist = MID_WET;
      o.moisture = MOIST_W'(moist);
      o.average  = SAMPLE_W'(avg);
      o.dry      = DRY_W'(dry);
      o.wet      = WET_W'(wet);
      return o;
    endfunction

    function void note_reading(probe_reading_t r);
      pending_readouts.push_back(moisture_readout_of(r));
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t MISMATCH %s", $time, msg);
    endtask

    task check_result(moisture_readout_t got);
      moisture_readout_t want;
      if (pending_readouts.size() == 0) begin
        report_mismatch($sformatf("unexpected readout moisture=%0d avg=%0d",
                                  got.moisture, got.average));
        return;
      end
      want = pending_readouts.pop_front();
      if (got.moisture !== want.moisture)
        report_mismatch($sformatf("moisture_hundredths got %0d want %0d",
                                  got.moisture, want.moisture));
      if (got.average !== want.average)
        report_mismatch($sformatf("soil_average got %0d want %0d",
                                  got.average, want.average));
      if (got.dry !== want.dry)
        report_mismatch($sformatf("dry_point got %0d want %0d", got.dry, want.dry));
      if (got.wet !== want.wet)
        report_mismatch($sformatf("wet_point got %0d want %0d", got.wet, want.wet));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  smpc_in_if  rd_if ();
  smpc_out_if res_if ();

  soil_moisture_percent_calc_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .reading     (rd_if),
    .result      (res_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  moisture_scoreboard sb;
  probe_reading_t     seen_reading;
  moisture_readout_t  seen_readout;
  int                 quiet_cycles = 0;

  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then long. A steady stretch
  // never idles.
  function automatic int pick_gap(bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic probe_reading_t reading_of(int supply, int a, int b, int c,
                                                int temp);
    probe_reading_t r;
    r.supply = SAMPLE_W'(supply);
    r.first  = SAMPLE_W'(a);
    r.second = SAMPLE_W'(b);
    r.third  = SAMPLE_W'(c);
    r.temp   = TEMP_W'(temp);
    return r;
  endfunction

  // Random reading. Most land around the calibration band so the
  // interpolation path is exercised; the rest are full-range or rail values.
  function automatic probe_reading_t random_reading();
    probe_reading_t    r;
    moisture_readout_t cal;
    int roll, t, target, k, v;
    r.supply = SAMPLE_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 70)
      t = int'($urandom_range(0, 1800)) - 550;
    else if (roll < 85)
      t = TEMP_REF + int'($urandom_range(0, 40)) - 20;
    else
      t = int'($urandom_range(0, 4095)) - 2048;
    r.temp = TEMP_W'(t);
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      cal = sb.moisture_readout_of(r);
      target = int'(cal.wet) - 40 +
               int'($urandom_range(0, int'(cal.dry) - int'(cal.wet) + 80));
      // undo the compensation so the corrected level sits in the band
      if (sb.comp_on) target += moisture_scoreboard::comp_counts(t - TEMP_REF);
      for (k = 0; k < 3; k++) begin
        v = target + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        case (k)
          0: r.first  = SAMPLE_W'(v);
          1: r.second = SAMPLE_W'(v);
          default: r.third = SAMPLE_W'(v);
        endcase
      end
    end else if (roll < 85) begin
      r.first  = SAMPLE_W'($urandom);
      r.second = SAMPLE_W'($urandom);
      r.third  = SAMPLE_W'($urandom);
    end else begin
      r.first  = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
      r.second = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'($urandom);
      r.third  = $urandom_range(0, 1) ? '0 : SAMPLE_W'($urandom);
    end
    return r;
  endfunction

  // Present one reading and hold it until the transaction is accepted.
  // Valid stays high on return so back-to-back readings need no toggle.
  task automatic drive_reading(probe_reading_t r, bit steady);
    int gap;
    gap = pick_gap(steady);
    if (gap > 0) begin
      rd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rd_if.valid              <= 1'b1;
    rd_if.supply_raw         <= r.supply;
    rd_if.soil_sample_first  <= r.first;
    rd_if.soil_sample_second <= r.second;
    rd_if.soil_sample_third  <= r.third;
    rd_if.temp_tenths        <= r.temp;
    do @(posedge clk); while (!rd_if.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted readout has come back,
  // then let the pipe settle.
  task automatic drain_pipeline();
    rd_if.valid <= 1'b0;
    while (sb.pending_readouts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the compensation enable while the block is idle.
  task automatic set_comp_enable(bit en);
    drain_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.comp_on = en;
  endtask

  // Directed readings: field extremes, rail temperature patterns,
  // calibration points hit exactly, the clamp at zero and the level
  // pushed above the sample range by a cold probe.
  task automatic run_directed();
    drive_reading(reading_of(0, 0, 0, 0, 0), 1'b0);
    drive_reading(reading_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 2047), 1'b0);
    drive_reading(reading_of(0, 0, 0, 0, -2048), 1'b0);
    // wet point for full supply, then the dry point
    drive_reading(reading_of(SAMPLE_MAX, 3461, 3461, 3461, TEMP_REF), 1'b0);
    drive_reading(reading_of(SAMPLE_MAX, 5219, 5219, 5219, TEMP_REF), 1'b0);
    drive_reading(reading_of(4000, 3500, 3400, 3602, TEMP_REF), 1'b0);
    drive_reading(reading_of(0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX - 1, 0), 1'b0);
    drive_reading(reading_of(2000, 3000, 3000, 3000, -550), 1'b0);
    drive_reading(reading_of(6000, 4000, 4001, 4002, 1250), 1'b0);
    // one tenth either side of the reference: truncation toward zero
    drive_reading(reading_of(3000, 3300, 3300, 3300, TEMP_REF + 1), 1'b0);
    drive_reading(reading_of(3000, 3300, 3300, 3300, TEMP_REF - 1), 1'b0);
    // hot probe drives the corrected level below zero
    drive_reading(reading_of(1234, 100, 90, 80, 2047), 1'b0);
  endtask

  // Result-side backpressure: runs of ready, short stalls, the odd long
  // stall and occasional long stretches with no stall at all.
  initial begin
    int run, stall;
    res_if.ready = 1'b0;
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                        : $urandom_range(1, 30);
      res_if.ready <= 1'b1;
      repeat (run) @(negedge clk);
      stall = pick_gap(1'b0);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Monitor: check result transactions first, then record readings, both
  // on the values present before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        seen_readout.moisture = res_if.moisture_hundredths;
        seen_readout.average  = res_if.soil_average;
        seen_readout.dry      = res_if.dry_point;
        seen_readout.wet      = res_if.wet_point;
        sb.check_result(seen_readout);
      end
      if (rd_if.valid && rd_if.ready) begin
        seen_reading.supply = rd_if.supply_raw;
        seen_reading.first  = rd_if.soil_sample_first;
        seen_reading.second = rd_if.soil_sample_second;
        seen_reading.third  = rd_if.soil_sample_third;
        seen_reading.temp   = rd_if.temp_tenths;
        sb.note_reading(seen_reading);
      end
      if ((res_if.valid && res_if.ready) || (rd_if.valid && rd_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Watchdog: give up when no transaction moves for too long.
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    bit steady;
    int phase, i;
    sb = new();
    rst                      = 1'b1;
    cfg_wr_en                = 1'b0;
    cfg_wr_data              = 1'b0;
    rd_if.valid              = 1'b0;
    rd_if.supply_raw         = '0;
    rd_if.soil_sample_first  = '0;
    rd_if.soil_sample_second = '0;
    rd_if.soil_sample_third  = '0;
    rd_if.temp_tenths        = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed set with compensation off, then on
    set_comp_enable(1'b0);
    run_directed();
    set_comp_enable(1'b1);
    run_directed();

    // random phases, alternating the compensation enable
    steady = 1'b0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_comp_enable(phase[0]);
      for (i = 0; i < READINGS_PER_PHASE; i++) begin
        if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        drive_reading(random_reading(), steady);
      end
    end

    drain_pipeline();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
sv/smpc_pkg.sv
sv/smpc_in_if.sv
sv/smpc_out_if.sv
sv/smpc_front.sv
sv/smpc_div.sv
sv/soil_moisture_percent_calc_unit.sv
tb/sv/soil_moisture_percent_calc_unit_test.sv
